// File: hdl/spmc_pkg.sv
// Shared types and constants of the stereo pixel match cost block.
`default_nettype none
package spmc_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_COST_MODE     = 2'd0;
    localparam logic [1:0] REG_COST_CUTOFF   = 2'd1;
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;

    // Cost mode codes as written to the mode register
    localparam logic [1:0] MODE_ABS = 2'd0;
    localparam logic [1:0] MODE_SQR = 2'd1;
    localparam logic [1:0] MODE_BT  = 2'd2;

    // Job kinds handed from the front to the back
    localparam logic [1:0] KIND_ABS = 2'd0;  // base value, clipped at cutoff
    localparam logic [1:0] KIND_SQR = 2'd1;  // base squared, clipped at cutoff
    localparam logic [1:0] KIND_BT  = 2'd2;  // base squared, no clip

    // Reset values of the registers
    localparam logic [1:0]  COST_MODE_RST     = MODE_ABS;
    localparam logic [15:0] COST_CUTOFF_RST   = 16'd65025;
    localparam logic [2:0]  CHANNEL_COUNT_RST = 3'd3;

    localparam int unsigned MAX_CHANNELS = 4;

    // Sum and mean limits
    localparam logic [18:0] SUM_MAX  = 19'd524287;
    localparam logic [23:0] MEAN_MAX = 24'd16646400;

    // floor(x / 3) = (x * DIV3_RECIP) >> DIV3_SHIFT for any 19-bit x
    localparam logic [17:0] DIV3_RECIP = 18'd174763;
    localparam int unsigned DIV3_SHIFT = 19;
    // floor(256 * r / 3) for remainders one and two
    localparam logic [7:0]  FRAC_THIRD     = 8'd85;
    localparam logic [7:0]  FRAC_TWO_THIRD = 8'd170;

    // Queue depths
    localparam int unsigned JOB_DEPTH = 4;
    localparam int unsigned RES_DEPTH = 4;
    localparam int unsigned JOB_PTR_W = $clog2(JOB_DEPTH);
    localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);

    // One classified channel job
    typedef struct packed {
        logic [7:0] base;
        logic [1:0] kind;
        logic       last;
    } t_job;

    // Handshake between job queue and back end
    typedef struct packed {
        logic empty;
        logic pop;
    } t_job_hs;

endpackage
`default_nettype wire

// File: hdl/spmc_front.sv
// Front end: classifies a channel request and forms its base difference.
`default_nettype none
module spmc_front
    import spmc_pkg::*;
(
    input  wire logic [1:0] i_cost_mode,
    input  wire logic [7:0] i_left_center,
    input  wire logic [7:0] i_left_before,
    input  wire logic [7:0] i_left_after,
    input  wire logic [7:0] i_right_center,
    input  wire logic [7:0] i_right_before,
    input  wire logic [7:0] i_right_after,
    input  wire logic       i_left_first_column,
    input  wire logic       i_left_final_column,
    input  wire logic       i_right_first_column,
    input  wire logic       i_right_final_column,
    input  wire logic       i_last_channel,
    output t_job            o_job
);

    // Half sample between centre and neighbour, or centre at an image edge
    function automatic logic [7:0] half_sample(input logic [7:0] c, input logic [7:0] n,
                                               input logic edge_flag);
        logic [8:0] s;
        begin
            s = {1'b0, c} + {1'b0, n};
            half_sample = edge_flag ? c : s[8:1];
        end
    endfunction

    function automatic logic [7:0] min8(input logic [7:0] a, input logic [7:0] b);
        min8 = (a < b) ? a : b;
    endfunction

    function automatic logic [7:0] max8(input logic [7:0] a, input logic [7:0] b);
        max8 = (a > b) ? a : b;
    endfunction

    // Distance of c outside [lo, hi]
    function automatic logic [7:0] outside(input logic [7:0] c, input logic [7:0] lo,
                                           input logic [7:0] hi);
        if (c > hi) begin
            outside = c - hi;
        end else if (c < lo) begin
            outside = lo - c;
        end else begin
            outside = 8'd0;
        end
    endfunction

    logic [7:0] abs_diff;
    logic [7:0] lh0, lh1, rh0, rh1;
    logic [7:0] lmin, lmax, rmin, rmax;
    logic [7:0] di1, di2, bt_base;

    // Plain absolute difference of the centres
    assign abs_diff = (i_left_center > i_right_center) ? (i_left_center - i_right_center)
                                                       : (i_right_center - i_left_center);

    // Interval bounds of each image
    assign lh0  = half_sample(i_left_center, i_left_before, i_left_first_column);
    assign lh1  = half_sample(i_left_center, i_left_after, i_left_final_column);
    assign rh0  = half_sample(i_right_center, i_right_before, i_right_first_column);
    assign rh1  = half_sample(i_right_center, i_right_after, i_right_final_column);
    assign lmin = min8(i_left_center, min8(lh0, lh1));
    assign lmax = max8(i_left_center, max8(lh0, lh1));
    assign rmin = min8(i_right_center, min8(rh0, rh1));
    assign rmax = max8(i_right_center, max8(rh0, rh1));

    // Sampling-insensitive distance
    assign di1     = outside(i_left_center, rmin, rmax);
    assign di2     = outside(i_right_center, lmin, lmax);
    assign bt_base = min8(di1, di2);

    // Classify by mode
    always_comb begin
        o_job.last = i_last_channel;
        case (i_cost_mode)
            MODE_SQR: begin
                o_job.kind = KIND_SQR;
                o_job.base = abs_diff;
            end
            MODE_BT: begin
                o_job.kind = KIND_BT;
                o_job.base = bt_base;
            end
            default: begin
                o_job.kind = KIND_ABS;
                o_job.base = abs_diff;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: hdl/spmc_job_q.sv
// Short job queue between front end and back end.
`default_nettype none
module spmc_job_q
    import spmc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_job    i_job,
    output logic         o_full,
    input  wire t_job_hs i_hs,
    output logic         o_empty,
    output t_job         o_job
);

    t_job                 r_mem [JOB_DEPTH];
    logic [JOB_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [JOB_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [JOB_PTR_W:0]   r_count, n_count;
    logic                 wr_en, rd_en;

    assign o_full  = (r_count == (JOB_PTR_W+1)'(JOB_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_hs.pop && !i_hs.empty;

    // Pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = wr_en ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = rd_en ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule
`default_nettype wire

// File: hdl/spmc_back.sv
// Back end: channel cost, running sum, mean by channel count, result queue.
`default_nettype none
module spmc_back
    import spmc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [15:0] i_cost_cutoff,
    input  wire logic [2:0]  i_channel_count,
    input  wire t_job        i_job,
    output t_job_hs          o_hs,
    input  wire logic        i_job_empty,
    output logic             o_empty,
    input  wire logic        i_pop,
    output logic [23:0]      o_mean_cost
);

    // Stage registers
    logic        r_c_valid;
    logic [15:0] r_c_cost;
    logic        r_c_last;
    logic [18:0] r_sum;
    logic        r_m_valid;
    logic [18:0] r_m_sum;
    logic        r_p_valid;
    logic [18:0] r_p_sum;
    logic [36:0] r_p_prod;

    // Result queue
    logic [23:0]          r_res_mem [RES_DEPTH];
    logic [RES_PTR_W-1:0] r_res_wr, r_res_rd;
    logic [RES_PTR_W:0]   r_res_cnt, n_res_cnt;
    logic                 res_full, res_wr, res_rd;

    logic        adv;
    logic        take;
    logic [15:0] sq;
    logic [15:0] pre_clip;
    logic [15:0] cost;
    logic [19:0] sum_add;
    logic [18:0] sum_next;
    logic [17:0] quot;
    logic [18:0] three_q;
    logic [18:0] rem_full;
    logic [7:0]  frac;
    logic [2:0]  cc;
    logic [26:0] mean_wide;
    logic [23:0] mean;

    // Whole back pipeline holds while a finished result cannot enter the queue
    assign res_full = (r_res_cnt == (RES_PTR_W+1)'(RES_DEPTH));
    assign adv      = !(r_p_valid && res_full);
    assign take     = adv && !i_job_empty;
    assign o_hs.pop   = take;
    assign o_hs.empty = i_job_empty;

    // Channel cost
    assign sq = {8'd0, i_job.base} * {8'd0, i_job.base};
    always_comb begin
        case (i_job.kind)
            KIND_SQR: pre_clip = sq;
            KIND_BT:  pre_clip = sq;
            default:  pre_clip = {8'd0, i_job.base};
        endcase
        if (i_job.kind == KIND_BT) begin
            cost = pre_clip;
        end else begin
            cost = (pre_clip < i_cost_cutoff) ? pre_clip : i_cost_cutoff;
        end
    end

    // Saturating running sum
    assign sum_add  = {1'b0, r_sum} + {4'd0, r_c_cost};
    assign sum_next = sum_add[19] ? SUM_MAX : sum_add[18:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_m_valid <= 1'b0;
            r_p_valid <= 1'b0;
            r_sum     <= '0;
        end else if (adv) begin
            r_c_valid <= take;
            r_m_valid <= r_c_valid && r_c_last;
            r_p_valid <= r_m_valid;
            if (r_c_valid) begin
                r_sum <= r_c_last ? '0 : sum_next;
            end
        end
    end

    // Payload of the stages
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c_cost <= cost;
            r_c_last <= i_job.last;
            r_m_sum  <= sum_next;
            r_p_sum  <= r_m_sum;
            r_p_prod <= {18'd0, r_m_sum} * {19'd0, DIV3_RECIP};
        end
    end

    // Divide by three: quotient from reciprocal, remainder to fraction bits
    assign quot     = r_p_prod[DIV3_SHIFT +: 18];
    assign three_q  = {1'b0, quot} + {quot, 1'b0};
    assign rem_full = r_p_sum - three_q;
    always_comb begin
        case (rem_full[1:0])
            2'd1:    frac = FRAC_THIRD;
            2'd2:    frac = FRAC_TWO_THIRD;
            default: frac = 8'd0;
        endcase
    end

    // Channel count clamped to one through four
    always_comb begin
        if (i_channel_count == 3'd0) begin
            cc = 3'd1;
        end else if (i_channel_count > 3'(MAX_CHANNELS)) begin
            cc = 3'(MAX_CHANNELS);
        end else begin
            cc = i_channel_count;
        end
    end

    always_comb begin
        case (cc)
            3'd2:    mean_wide = {1'b0, r_p_sum, 7'd0};
            3'd3:    mean_wide = {1'b0, quot, frac};
            3'd4:    mean_wide = {2'd0, r_p_sum, 6'd0};
            default: mean_wide = {r_p_sum, 8'd0};
        endcase
        mean = (mean_wide > {3'd0, MEAN_MAX}) ? MEAN_MAX : mean_wide[23:0];
    end

    // Result queue bookkeeping
    assign res_wr      = r_p_valid && !res_full;
    assign res_rd      = i_pop && !o_empty;
    assign o_empty     = (r_res_cnt == '0);
    assign o_mean_cost = r_res_mem[r_res_rd];

    always_comb begin
        n_res_cnt = r_res_cnt;
        if (res_wr && !res_rd) begin
            n_res_cnt = r_res_cnt + 1'b1;
        end else if (res_rd && !res_wr) begin
            n_res_cnt = r_res_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_wr  <= '0;
            r_res_rd  <= '0;
            r_res_cnt <= '0;
        end else begin
            r_res_cnt <= n_res_cnt;
            if (res_wr) begin
                r_res_wr <= r_res_wr + 1'b1;
            end
            if (res_rd) begin
                r_res_rd <= r_res_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_wr) begin
            r_res_mem[r_res_wr] <= mean;
        end
    end

endmodule
`default_nettype wire

// File: hdl/stereo_pixel_match_cost_top.sv
// Top level of the stereo pixel match cost block.
//
// Input queue side: one colour channel of a left/right pixel pair per request,
// taken when push is high and full is low. The request flagged last_channel
// closes the pair; it alone yields a result, the channel-averaged cost in
// unsigned fixed point with 8 fraction bits.
// Result queue side: o_mean_cost holds the oldest result while empty is low;
// pop takes it.
// Configuration: i_cfg_valid/o_cfg_ready with a register index and data;
// o_cfg_ready is always high. Writes only while the block is idle.
// Throughput: one channel request per cycle while neither queue fills.
// A result passes the job queue read and the cost, sum and reciprocal multiply
// registers before it enters the result queue.
// A 4-entry job queue parts front from back; a 4-entry result queue parts the
// back from the receiver. When the receiver stalls, the result queue fills,
// the back end holds, the job queue fills and full rises.
// Reset (synchronous, active low) empties both queues, clears the running sum
// and restores mode absolute, cutoff 65025 and channel count 3.
`default_nettype none
module stereo_pixel_match_cost_top
    import spmc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_left_center,
    input  wire logic [7:0]  i_left_before,
    input  wire logic [7:0]  i_left_after,
    input  wire logic [7:0]  i_right_center,
    input  wire logic [7:0]  i_right_before,
    input  wire logic [7:0]  i_right_after,
    input  wire logic        i_left_first_column,
    input  wire logic        i_left_final_column,
    input  wire logic        i_right_first_column,
    input  wire logic        i_right_final_column,
    input  wire logic        i_last_channel,
    output logic             empty,
    input  wire logic        pop,
    output logic [23:0]      o_mean_cost,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    logic [1:0]  r_cost_mode;
    logic [15:0] r_cost_cutoff;
    logic [2:0]  r_channel_count;

    t_job    front_job;
    t_job    queue_job;
    t_job_hs job_hs;
    logic    job_empty;

    // Configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cost_mode     <= COST_MODE_RST;
            r_cost_cutoff   <= COST_CUTOFF_RST;
            r_channel_count <= CHANNEL_COUNT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_COST_MODE:     r_cost_mode     <= i_cfg_data[1:0];
                REG_COST_CUTOFF:   r_cost_cutoff   <= i_cfg_data;
                REG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    spmc_front u_front (
        .i_cost_mode          (r_cost_mode),
        .i_left_center        (i_left_center),
        .i_left_before        (i_left_before),
        .i_left_after         (i_left_after),
        .i_right_center       (i_right_center),
        .i_right_before       (i_right_before),
        .i_right_after        (i_right_after),
        .i_left_first_column  (i_left_first_column),
        .i_left_final_column  (i_left_final_column),
        .i_right_first_column (i_right_first_column),
        .i_right_final_column (i_right_final_column),
        .i_last_channel       (i_last_channel),
        .o_job                (front_job)
    );

    spmc_job_q u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .i_hs    (job_hs),
        .o_empty (job_empty),
        .o_job   (queue_job)
    );

    spmc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cost_cutoff   (r_cost_cutoff),
        .i_channel_count (r_channel_count),
        .i_job           (queue_job),
        .o_hs            (job_hs),
        .i_job_empty     (job_empty),
        .o_empty         (empty),
        .i_pop           (pop),
        .o_mean_cost     (o_mean_cost)
    );

    // A shown result never exceeds the mean limit
    a_mean_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_mean_cost <= MEAN_MAX))
        else $error("mean cost above limit");

    // Both queues come out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!full && empty))
        else $error("queues not empty after reset");

    // The back end never takes a job from an empty job queue
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_hs.pop |-> !job_empty)
        else $error("job taken from empty queue");

endmodule
`default_nettype wire

// File: tb/tb_stereo_pixel_match_cost_top.sv
// Self-checking testbench for the stereo pixel match cost block: queued channel requests in, mean costs out.
module tb_stereo_pixel_match_cost_top;
    timeunit 1ns;
    timeprecision 1ps;
    import spmc_pkg::*;

    // Register index past the list, and the mode code that behaves as absolute
    localparam logic [1:0] REG_UNUSED     = 2'd3;
    localparam logic [1:0] MODE_ABS_ALIAS = 2'd3;

    // Flag vectors for make_req: {left first, left final, right first, right final, last}
    localparam logic [4:0] F_NONE   = 5'b00000;
    localparam logic [4:0] F_LFIRST = 5'b10000;
    localparam logic [4:0] F_LFINAL = 5'b01000;
    localparam logic [4:0] F_RFIRST = 5'b00100;
    localparam logic [4:0] F_RFINAL = 5'b00010;
    localparam logic [4:0] F_LAST   = 5'b00001;

    localparam int unsigned N_PHASES    = 12;
    localparam int unsigned PHASE_ITEMS = 160;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned DRAIN_PAUSE = 10;

    // One channel request as presented on the input ports
    typedef struct packed {
        logic [7:0] left_center;
        logic [7:0] left_before;
        logic [7:0] left_after;
        logic [7:0] right_center;
        logic [7:0] right_before;
        logic [7:0] right_after;
        logic       left_first_column;
        logic       left_final_column;
        logic       right_first_column;
        logic       right_final_column;
        logic       last_channel;
    } chan_req_t;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        push        = 1'b0;
    logic        full;
    logic        empty;
    logic        pop         = 1'b0;
    logic [23:0] mean_cost;
    logic        i_cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data  = '0;
    chan_req_t   cur_req     = '0;

    // Requests waiting for the driver; head is removed only once accepted
    chan_req_t   pending_reqs[$];
    // Mean costs still owed by the block, oldest first
    logic [23:0] expected_means[$];

    // Predictor state: register copies and the channel cost sum of the open pair
    logic [1:0]  cfg_mode   = COST_MODE_RST;
    logic [15:0] cfg_cutoff = COST_CUTOFF_RST;
    logic [2:0]  cfg_count  = CHANNEL_COUNT_RST;
    logic [18:0] chan_sum   = '0;

    int unsigned fault_count  = 0;
    int unsigned stall_cycles = 0;
    int unsigned hold_left    = 0;
    bit          hold_done    = 1'b0;
    bit          hold_phase   = 1'b0;
    bit          steady       = 1'b0;

    stereo_pixel_match_cost_top u_top (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .push                 (push),
        .full                 (full),
        .i_left_center        (cur_req.left_center),
        .i_left_before        (cur_req.left_before),
        .i_left_after         (cur_req.left_after),
        .i_right_center       (cur_req.right_center),
        .i_right_before       (cur_req.right_before),
        .i_right_after        (cur_req.right_after),
        .i_left_first_column  (cur_req.left_first_column),
        .i_left_final_column  (cur_req.left_final_column),
        .i_right_first_column (cur_req.right_first_column),
        .i_right_final_column (cur_req.right_final_column),
        .i_last_channel       (cur_req.last_channel),
        .empty                (empty),
        .pop                  (pop),
        .o_mean_cost          (mean_cost),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int unsigned lo2(int unsigned a, int unsigned b);
        return (a < b) ? a : b;
    endfunction

    function automatic int unsigned hi2(int unsigned a, int unsigned b);
        return (a > b) ? a : b;
    endfunction

    // Half-sample towards a neighbour; the centre itself at an image border
    function automatic int unsigned half_sample(logic [7:0] c, logic [7:0] n, logic at_border);
        return at_border ? 32'(c) : (32'(c) + 32'(n)) >> 1;
    endfunction

    // Distance of c outside [lo, hi], zero inside
    function automatic int unsigned dist_outside(int unsigned c, int unsigned lo,
                                                 int unsigned hi);
        if (c > hi) return c - hi;
        if (c < lo) return lo - c;
        return 0;
    endfunction

    // Cost of one channel under the current mode and cutoff
    function automatic int unsigned channel_cost(chan_req_t r);
        int unsigned lc, rc, d, lh0, lh1, rh0, rh1, lmin, lmax, rmin, rmax, b;
        lc = 32'(r.left_center);
        rc = 32'(r.right_center);
        d  = (lc > rc) ? lc - rc : rc - lc;
        case (cfg_mode)
            MODE_SQR: return lo2(d * d, 32'(cfg_cutoff));
            MODE_BT: begin
                lh0  = half_sample(r.left_center, r.left_before, r.left_first_column);
                lh1  = half_sample(r.left_center, r.left_after, r.left_final_column);
                rh0  = half_sample(r.right_center, r.right_before, r.right_first_column);
                rh1  = half_sample(r.right_center, r.right_after, r.right_final_column);
                lmin = lo2(lc, lo2(lh0, lh1));
                lmax = hi2(lc, hi2(lh0, lh1));
                rmin = lo2(rc, lo2(rh0, rh1));
                rmax = hi2(rc, hi2(rh0, rh1));
                b = lo2(dist_outside(lc, rmin, rmax), dist_outside(rc, lmin, lmax));
                return b * b;
            end
            default: return lo2(d, 32'(cfg_cutoff));
        endcase
    endfunction

    function automatic chan_req_t make_req(logic [7:0] lc, logic [7:0] lb, logic [7:0] la,
                                           logic [7:0] rc, logic [7:0] rb, logic [7:0] ra,
                                           logic [4:0] flags);
        return chan_req_t'({lc, lb, la, rc, rb, ra, flags});
    endfunction

    // Samples lean towards the range ends
    function automatic logic [7:0] pick_sample();
        case ($urandom_range(7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic chan_req_t random_req(logic last);
        chan_req_t r;
        r.left_center        = pick_sample();
        r.left_before        = pick_sample();
        r.left_after         = pick_sample();
        r.right_center       = pick_sample();
        r.right_before       = pick_sample();
        r.right_after        = pick_sample();
        r.left_first_column  = ($urandom_range(3) == 0);
        r.left_final_column  = ($urandom_range(3) == 0);
        r.right_first_column = ($urandom_range(3) == 0);
        r.right_final_column = ($urandom_range(3) == 0);
        r.last_channel       = last;
        return r;
    endfunction

    // Mostly whole pixel pairs; some odd-length pairs and some without a closing channel
    task automatic queue_pairs(int unsigned n_items, int unsigned per_pair);
        int unsigned left_n, len;
        left_n = n_items;
        while (left_n > 0) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(1, 12) : per_pair;
            if (len > left_n) len = left_n;
            for (int unsigned k = 0; k < len; k++)
                pending_reqs.push_back(random_req(k == len - 1 && $urandom_range(19) != 0));
            left_n -= len;
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!cfg_ready);
        case (idx)
            REG_COST_MODE:     cfg_mode   = data[1:0];
            REG_COST_CUTOFF:   cfg_cutoff = data;
            REG_CHANNEL_COUNT: cfg_count  = data[2:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    // Unused data bits carry random values
    task automatic configure(logic [1:0] mode, logic [15:0] cutoff, logic [2:0] count);
        write_reg(REG_COST_MODE, {14'($urandom), mode});
        write_reg(REG_COST_CUTOFF, cutoff);
        write_reg(REG_CHANNEL_COUNT, {13'($urandom), count});
    endtask

    // Everything sent and answered, then room for channels still in the pipeline
    task automatic wait_drained();
        while (pending_reqs.size() != 0 || expected_means.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAUSE) @(posedge i_clk);
    endtask

    // Driver: presents the head request, predicts on acceptance
    always @(posedge i_clk) begin : drive_proc
        int unsigned cost, sum_ext, divisor, mean;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                cost    = channel_cost(cur_req);
                sum_ext = 32'(chan_sum) + cost;
                chan_sum = (sum_ext > SUM_MAX) ? SUM_MAX : sum_ext[18:0];
                if (cur_req.last_channel) begin
                    divisor = (cfg_count == 0) ? 1 :
                              (cfg_count > MAX_CHANNELS) ? MAX_CHANNELS : 32'(cfg_count);
                    mean = (32'(chan_sum) << 8) / divisor;
                    if (mean > MEAN_MAX) mean = 32'(MEAN_MAX);
                    expected_means.push_back(mean[23:0]);
                    chan_sum = '0;
                end
                void'(pending_reqs.pop_front());
            end
            if (push && full) begin
                // request stays on the ports until taken
            end else if (pending_reqs.size() != 0 && (steady || $urandom_range(99) >= 30)) begin
                cur_req <= pending_reqs[0];
                push    <= 1'b1;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Monitor: checks each popped mean cost and paces the receiver
    always @(posedge i_clk) begin : watch_proc
        logic [23:0] want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_means.size() == 0) begin
                    if (fault_count < 10)
                        $display("unexpected mean_cost %0d", mean_cost);
                    fault_count++;
                end else begin
                    want = expected_means.pop_front();
                    if (mean_cost !== want) begin
                        if (fault_count < 10)
                            $display("mean_cost mismatch: expected %0d, got %0d", want, mean_cost);
                        fault_count++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (hold_phase && !hold_done) begin
                // long back-pressure so both queues fill and full rises
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
                pop <= 1'b0;
            end else begin
                pop <= steady || ($urandom_range(99) >= 30);
            end
        end
    end

    // Watchdog on cycles without any accepted request
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [1:0]  pm;
        logic [15:0] pc;
        logic [2:0]  pn;
        int unsigned eff;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: absolute cost, full cutoff, three channels
        pending_reqs.push_back(make_req(255, 0, 255, 0, 255, 0, F_NONE));
        pending_reqs.push_back(make_req(0, 255, 0, 255, 0, 255, F_NONE));
        pending_reqs.push_back(make_req(128, 0, 0, 128, 255, 255, F_LAST));
        pending_reqs.push_back(make_req(255, 255, 255, 255, 255, 255,
                                        F_LFIRST | F_LFINAL | F_RFIRST | F_RFINAL | F_LAST));
        pending_reqs.push_back(make_req(0, 0, 0, 255, 255, 255, F_LAST));
        wait_drained();

        // Write to the spare index must change nothing; BT ignores a zero cutoff
        write_reg(REG_UNUSED, 16'hFFFF);
        configure(MODE_BT, 16'd0, 3'd4);
        // border flags: both on one side, then mixed
        pending_reqs.push_back(make_req(10, 200, 0, 100, 90, 110, F_LFIRST | F_LFINAL));
        pending_reqs.push_back(make_req(100, 90, 110, 10, 200, 0, F_RFIRST | F_RFINAL));
        pending_reqs.push_back(make_req(50, 0, 255, 200, 255, 0, F_LFIRST | F_RFINAL));
        pending_reqs.push_back(make_req(200, 255, 0, 50, 0, 255,
                                        F_LFINAL | F_RFIRST | F_LAST));
        // largest BT pair exactly at the mean limit, then one channel too many,
        // then enough channels to saturate the sum
        for (int unsigned k = 0; k < 4; k++)
            pending_reqs.push_back(make_req(255, 255, 255, 0, 0, 0, (k == 3) ? F_LAST : F_NONE));
        for (int unsigned k = 0; k < 5; k++)
            pending_reqs.push_back(make_req(255, 255, 255, 0, 0, 0, (k == 4) ? F_LAST : F_NONE));
        for (int unsigned k = 0; k < 9; k++)
            pending_reqs.push_back(make_req(255, 255, 255, 0, 0, 0, (k == 8) ? F_LAST : F_NONE));
        wait_drained();

        // Squared cost against a cutoff
        configure(MODE_SQR, 16'd1000, 3'd2);
        pending_reqs.push_back(make_req(255, 1, 2, 0, 3, 4, F_NONE));
        pending_reqs.push_back(make_req(10, 5, 6, 0, 7, 8, F_LAST));
        wait_drained();

        // Random phases over a spread of settings, extremes first
        for (int unsigned p = 0; p < N_PHASES; p++) begin
            case (p)
                0: begin pm = MODE_ABS;       pc = 16'd65025; pn = 3'd3; end
                1: begin pm = MODE_SQR;       pc = 16'd65025; pn = 3'd4; end
                2: begin pm = MODE_BT;        pc = 16'd0;     pn = 3'd1; end
                3: begin pm = MODE_ABS_ALIAS; pc = 16'd100;   pn = 3'd2; end
                4: begin pm = MODE_SQR;       pc = 16'd0;     pn = 3'd0; end
                5: begin pm = MODE_ABS;       pc = 16'd65535; pn = 3'd7; end
                6: begin pm = MODE_BT;        pc = 16'd65535; pn = 3'd5; end
                7: begin pm = MODE_SQR;       pc = 16'd1000;  pn = 3'd3; end
                8: begin pm = MODE_ABS;       pc = 16'd1;     pn = 3'd4; end
                default: begin
                    pm = 2'($urandom_range(3));
                    pc = 16'($urandom_range(65535));
                    pn = 3'($urandom_range(7));
                end
            endcase
            steady = (p == 0);
            configure(pm, pc, pn);
            hold_phase = (p == 3);
            eff = (pn == 0) ? 1 : (pn > MAX_CHANNELS) ? MAX_CHANNELS : 32'(pn);
            queue_pairs(PHASE_ITEMS, eff);
            wait_drained();
        end

        fault_count += expected_means.size();
        if (fault_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: files.f
hdl/spmc_pkg.sv
hdl/spmc_front.sv
hdl/spmc_job_q.sv
hdl/spmc_back.sv
hdl/stereo_pixel_match_cost_top.sv
tb/tb_stereo_pixel_match_cost_top.sv
